FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion, checked during reset as well.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: src/mrsm_pkg.sv
// Types, constants and the CRC step shared by the Modbus RTU master modules.
package mrsm_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_RX      = 2'd2,
    MODE_TIMEOUT = 2'd3
  } mode_t;

  localparam logic [7:0] FUNC_WRITE      = 8'd6;
  localparam logic [7:0] FUNC_READ_HOLD  = 8'd3;
  localparam logic [7:0] FUNC_READ_INPUT = 8'd4;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd1;

  localparam logic [7:0]  RESET_SLAVE_ADDR   = 8'h01;
  localparam logic [3:0]  RESET_MAX_ATTEMPTS = 4'd3;
  localparam logic [15:0] CRC_INIT           = 16'hFFFF;
  localparam logic [15:0] CRC_POLY           = 16'hA001;
  localparam logic [15:0] READ_REG_COUNT     = 16'h0001;
  localparam logic [7:0]  READ_BYTE_COUNT    = 8'h02;

  // Frame byte positions
  localparam logic [2:0] FB_ADDR    = 3'd0;
  localparam logic [2:0] FB_FUNC    = 3'd1;
  localparam logic [2:0] FB_REG_HI  = 3'd2;
  localparam logic [2:0] FB_REG_LO  = 3'd3;
  localparam logic [2:0] FB_VAL_HI  = 3'd4;
  localparam logic [2:0] FB_VAL_LO  = 3'd5;
  localparam logic [2:0] FB_CRC_LO  = 3'd6;
  localparam logic [2:0] FB_CRC_HI  = 3'd7;

  // Reply positions
  localparam logic [2:0] RX_LAST_READ  = 3'd6;
  localparam logic [2:0] RX_LAST_WRITE = 3'd7;
  localparam int unsigned RX_HDR_LEN   = 5;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = Q_PTR_W + 1;

  typedef struct packed {
    logic        fin;
    logic        success;
    logic [15:0] read_value;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [15:0] reg_num;
    logic [15:0] value;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: src/mrsm_front.sv
// Front end: config registers, transaction state, reply checking, job issue.
module mrsm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     mode,
  input  logic [15:0]                    reg_address,
  input  logic [15:0]                    write_value,
  input  logic [7:0]                     rx_byte,
  output logic                           q_push,
  output mrsm_pkg::job_t                 q_job,
  input  logic                           q_full
);

  logic [7:0]  slave_address;
  logic [3:0]  max_attempts;
  logic        busy, busy_next;
  logic        is_read, is_read_next;
  logic [7:0]  func, func_next;
  logic [3:0]  attempt, attempt_next;
  logic [2:0]  rx_count, rx_count_next;
  logic [15:0] target, target_next;
  logic [15:0] stored, stored_next;
  logic [7:0]  rx_hdr [mrsm_pkg::RX_HDR_LEN];
  logic [7:0]  rx_lo;
  logic [15:0] rx_crc;
  logic [15:0] crc_base;

  logic        accept, send, finish, fail, ok;
  logic [15:0] fin_value;
  logic [3:0]  lim;
  logic [2:0]  last_idx;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;
  assign lim       = (max_attempts == 4'd0) ? 4'd1 : max_attempts;
  assign last_idx  = is_read ? mrsm_pkg::RX_LAST_READ : mrsm_pkg::RX_LAST_WRITE;
  assign crc_base  = (rx_count == 3'd0) ? mrsm_pkg::CRC_INIT : rx_crc;

  assign ok = (rx_hdr[0] == slave_address) && (rx_hdr[1] == func) &&
              (!is_read || rx_hdr[2] == mrsm_pkg::READ_BYTE_COUNT) &&
              (rx_lo == rx_crc[7:0]) && (rx_byte == rx_crc[15:8]);

  always_comb begin
    busy_next     = busy;
    is_read_next  = is_read;
    func_next     = func;
    attempt_next  = attempt;
    rx_count_next = rx_count;
    target_next   = target;
    stored_next   = stored;
    send          = 1'b0;
    finish        = 1'b0;
    fail          = 1'b0;
    fin_value     = 16'h0000;
    unique case (mrsm_pkg::mode_t'(mode))
      mrsm_pkg::MODE_WRITE, mrsm_pkg::MODE_READ: begin
        is_read_next = (mrsm_pkg::mode_t'(mode) == mrsm_pkg::MODE_READ);
        func_next    = is_read_next ? mrsm_pkg::FUNC_READ_HOLD : mrsm_pkg::FUNC_WRITE;
        target_next  = reg_address;
        stored_next  = is_read_next ? mrsm_pkg::READ_REG_COUNT : write_value;
        attempt_next = 4'd1;
        send         = 1'b1;
      end
      mrsm_pkg::MODE_TIMEOUT: begin
        fail = busy;
      end
      mrsm_pkg::MODE_RX: begin
        if (busy) begin
          rx_count_next = rx_count + 3'd1;
          if (rx_count == last_idx) begin
            if (ok) begin
              finish    = 1'b1;
              fin_value = is_read ? {rx_hdr[3], rx_hdr[4]} : 16'h0000;
            end else begin
              fail = 1'b1;
            end
          end
        end
      end
    endcase
    if (fail) begin
      if (attempt < lim) begin
        attempt_next = attempt + 4'd1;
        send         = 1'b1;
      end else if (is_read && func == mrsm_pkg::FUNC_READ_HOLD) begin
        func_next    = mrsm_pkg::FUNC_READ_INPUT;
        attempt_next = 4'd1;
        send         = 1'b1;
      end else begin
        finish = 1'b1;
      end
    end
    if (send) begin
      busy_next     = 1'b1;
      rx_count_next = 3'd0;
    end else if (finish) begin
      busy_next     = 1'b0;
      rx_count_next = 3'd0;
    end
  end

  assign q_push             = accept && (send || finish);
  assign q_job.fin          = finish;
  assign q_job.success      = finish && !fail;
  assign q_job.read_value   = fin_value;
  assign q_job.addr         = slave_address;
  assign q_job.func         = func_next;
  assign q_job.reg_num      = target_next;
  assign q_job.value        = stored_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= mrsm_pkg::RESET_SLAVE_ADDR;
      max_attempts  <= mrsm_pkg::RESET_MAX_ATTEMPTS;
    end else if (cfg_valid) begin
      case (cfg_index)
        mrsm_pkg::CFG_SLAVE_ADDR:   slave_address <= cfg_data;
        mrsm_pkg::CFG_MAX_ATTEMPTS: max_attempts  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      is_read  <= 1'b0;
      func     <= 8'h00;
      attempt  <= 4'd0;
      rx_count <= 3'd0;
      target   <= 16'h0000;
      stored   <= 16'h0000;
    end else if (accept) begin
      busy     <= busy_next;
      is_read  <= is_read_next;
      func     <= func_next;
      attempt  <= attempt_next;
      rx_count <= rx_count_next;
      target   <= target_next;
      stored   <= stored_next;
    end
  end

  // Reply bytes: header kept, CRC run over everything before the CRC field.
  always_ff @(posedge clk) begin
    if (accept && busy && mrsm_pkg::mode_t'(mode) == mrsm_pkg::MODE_RX) begin
      if (rx_count < 3'(mrsm_pkg::RX_HDR_LEN)) begin
        rx_hdr[rx_count] <= rx_byte;
      end
      if (rx_count < last_idx - 3'd1) begin
        rx_crc <= mrsm_pkg::crc_byte(crc_base, rx_byte);
      end
      if (rx_count == last_idx - 3'd1) begin
        rx_lo <= rx_byte;
      end
    end
  end

endmodule

FILE: src/mrsm_queue.sv
// Short job queue between the front end and the frame serializer.
module mrsm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrsm_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output mrsm_pkg::job_t pop_job,
  output logic           empty
);

  mrsm_pkg::job_t                 slots [mrsm_pkg::Q_DEPTH];
  logic [mrsm_pkg::Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [mrsm_pkg::Q_CNT_W-1:0]   count;

  assign full    = (count == mrsm_pkg::Q_CNT_W'(mrsm_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mrsm_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mrsm_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + mrsm_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - mrsm_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

FILE: src/mrsm_back.sv
// Back end: serializes request frames with CRC and finish results into the output register.
module mrsm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  mrsm_pkg::job_t q_job,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic           kind,
  output logic [7:0]     tx_byte,
  output logic           last,
  output logic           success,
  output logic [15:0]    read_value,
  output logic           comm_fault
);

  mrsm_pkg::job_t job;
  logic           active;
  logic [2:0]     idx;
  logic [15:0]    crc;
  logic           out_valid;
  logic           emit, emit_last;
  logic [7:0]     frame_byte;

  always_comb begin
    unique case (idx)
      mrsm_pkg::FB_ADDR:   frame_byte = job.addr;
      mrsm_pkg::FB_FUNC:   frame_byte = job.func;
      mrsm_pkg::FB_REG_HI: frame_byte = job.reg_num[15:8];
      mrsm_pkg::FB_REG_LO: frame_byte = job.reg_num[7:0];
      mrsm_pkg::FB_VAL_HI: frame_byte = job.value[15:8];
      mrsm_pkg::FB_VAL_LO: frame_byte = job.value[7:0];
      mrsm_pkg::FB_CRC_LO: frame_byte = crc[7:0];
      mrsm_pkg::FB_CRC_HI: frame_byte = crc[15:8];
    endcase
  end

  assign emit      = active && (!out_valid || pop);
  assign emit_last = job.fin || (idx == mrsm_pkg::FB_CRC_HI);
  assign q_pop     = !q_empty && (!active || (emit && emit_last));
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 3'd0;
    end else if (q_pop) begin
      active <= 1'b1;
      idx    <= 3'd0;
    end else if (emit) begin
      if (emit_last) begin
        active <= 1'b0;
      end
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
      crc <= mrsm_pkg::CRC_INIT;
    end else if (emit && idx < mrsm_pkg::FB_CRC_LO) begin
      crc <= mrsm_pkg::crc_byte(crc, frame_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind       <= job.fin;
      tx_byte    <= job.fin ? 8'h00 : frame_byte;
      last       <= emit_last;
      success    <= job.fin && job.success;
      read_value <= job.fin ? job.read_value : 16'h0000;
      comm_fault <= job.fin && !job.success;
    end
  end

endmodule

FILE: src/modbus_rtu_single_register_master.sv
// An accepted start goes to the job queue, then the serializer's job register; its first
// frame byte is then registered on the result side. Throughput: one result per cycle
// from the serializer while pop drains the output; a reply byte or timeout is accepted
// every cycle while the 2-entry job queue has room. The front end checks received bytes
// one per cycle, when accepted, against a running CRC. Reset (synchronous, active high)
// clears queue, output and transaction state, and sets slave_address 1, max_attempts 3.
module modbus_rtu_single_register_master (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     mode,
  input  logic [15:0]                    reg_address,
  input  logic [15:0]                    write_value,
  input  logic [7:0]                     rx_byte,
  output logic                           empty,
  input  logic                           pop,
  output logic                           kind,
  output logic [7:0]                     tx_byte,
  output logic                           last,
  output logic                           success,
  output logic [15:0]                    read_value,
  output logic                           comm_fault
);

  logic           q_push, q_full, q_pop, q_empty;
  mrsm_pkg::job_t q_in, q_out;

  mrsm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .reg_address (reg_address),
    .write_value (write_value),
    .rx_byte     (rx_byte),
    .q_push      (q_push),
    .q_job       (q_in),
    .q_full      (q_full)
  );

  mrsm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_out),
    .empty    (q_empty)
  );

  mrsm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_job      (q_out),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .tx_byte    (tx_byte),
    .last       (last),
    .success    (success),
    .read_value (read_value),
    .comm_fault (comm_fault)
  );

endmodule

FILE: src/mrsm_checker.sv
// Port-level checks on the result side of the Modbus RTU master, bound to the top level.
`include "assert_macros.svh"

module mrsm_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic        kind,
  input logic [7:0]  tx_byte,
  input logic        last,
  input logic        success,
  input logic [15:0] read_value,
  input logic        comm_fault
);

  `ASSERT_CLK(a_rst_empty, clk, rst |=> empty)
  `ASSERT_CLK_RST(a_fin_last, clk, rst, !empty && kind |-> last && tx_byte == 8'h00)
  `ASSERT_CLK_RST(a_fin_fault, clk, rst, !empty && kind |-> success != comm_fault)
  `ASSERT_CLK_RST(a_tx_clean, clk, rst, !empty && !kind |-> !success && !comm_fault && read_value == 16'h0000)
  `ASSERT_CLK_RST(a_hold, clk, rst, !empty && !pop |=> !empty && $stable(tx_byte) && $stable(kind))

endmodule

bind modbus_rtu_single_register_master mrsm_port_checker u_mrsm_port_checker (.*);
